### sv/scg_pkg.sv
// Shared types and constants for the sparse column scatter/gather block.
`default_nettype none
package scg_pkg;

	localparam logic [1:0] ACT_SCATTER = 2'd0;
	localparam logic [1:0] ACT_PROBE   = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;
	localparam logic [1:0] ACT_END     = 2'd3;

	localparam logic [63:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        row_index;
		logic [15:0]        position;
		logic signed [63:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        hit_position;
		logic signed [63:0] hit_value;
		logic               column_end;
		logic [31:0]        total_count;
	} out_item_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} store_cmd_t;

endpackage
`default_nettype wire

### sv/scg_column_store.sv
// Dense column value store with a zeroing sweep after reset.
`default_nettype none
module scg_column_store #(
	parameter int DEPTH = 65536
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  scg_pkg::store_cmd_t         cmd,
	input  wire [$clog2(DEPTH)-1:0]     addr,
	input  wire [63:0]                  wdata,
	output logic [63:0]                 rdata,
	output logic                        busy
);

	localparam int AW = $clog2(DEPTH);

	logic [63:0]   mem [DEPTH];
	logic          sweep_q;
	logic [AW-1:0] sweep_addr_q;

	assign busy = sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + AW'(1);
			if (sweep_addr_q == AW'(DEPTH - 1)) begin
				sweep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			mem[sweep_addr_q] <= 64'd0;
		end else if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

### sv/sparse_column_scatter_gather.sv
// Top level of the sparse column scatter/gather block.
// Takes one beat per cycle when not stalled by the reset sweep or output
// back-pressure: scatter and clear write the dense column store, probe
// reads it and returns (position, value) when the stored value is nonzero
// ignoring the sign bit, end of column returns the saturating count of hits
// so far. A result passes from the store read register into the output
// register, which loads only when empty or being drained. After reset the
// store is zeroed, one row per cycle over MAX_ROWS rows, with in_ready low.
`default_nettype none
module sparse_column_scatter_gather #(
	parameter int MAX_ROWS        = 65536,
	parameter int MAX_SUBSET_ROWS = 65536
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  scg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output scg_pkg::out_item_t out_data
);

	localparam int AW = $clog2(MAX_ROWS);

	scg_pkg::store_cmd_t cmd;
	logic [AW-1:0]       addr;
	logic [63:0]         wdata;
	logic [63:0]         rdata;
	logic                busy;
	logic                accept;
	logic                row_ok;
	logic                pos_ok;
	logic [31:0]         row_ext;

	logic                valid_s1;
	logic                probe_s1;
	logic                end_s1;
	logic [15:0]         pos_s1;

	logic                go_s1;
	logic                hit;
	logic                produce;
	logic [31:0]         count_next;

	logic                out_valid_q;
	scg_pkg::out_item_t  out_q;
	logic [31:0]         count_q;

	assign row_ext = 32'(in_data.row_index);
	assign row_ok  = row_ext < 32'(MAX_ROWS);
	assign pos_ok  = 32'(in_data.position) < 32'(MAX_SUBSET_ROWS);
	assign addr    = row_ext[AW-1:0];

	assign go_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !busy && (!valid_s1 || go_s1);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd   = '0;
		wdata = 64'd0;
		unique case (in_data.action)
			scg_pkg::ACT_SCATTER: begin
				cmd.wr = accept && row_ok;
				wdata  = in_data.entry_value;
			end
			scg_pkg::ACT_PROBE: begin
				cmd.rd = accept && row_ok;
			end
			scg_pkg::ACT_CLEAR: begin
				cmd.wr = accept && row_ok;
			end
			scg_pkg::ACT_END: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	scg_column_store #(
		.DEPTH (MAX_ROWS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (addr),
		.wdata  (wdata),
		.rdata  (rdata),
		.busy   (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			probe_s1 <= 1'b0;
			end_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			probe_s1 <= (in_data.action == scg_pkg::ACT_PROBE) && row_ok && pos_ok;
			end_s1   <= in_data.action == scg_pkg::ACT_END;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= in_data.position;
		end
	end

	assign hit        = probe_s1 && ((rdata & scg_pkg::MAG_MASK) != 64'd0);
	assign produce    = hit || end_s1;
	assign count_next = (count_q == scg_pkg::COUNT_MAX) ? count_q : count_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= 32'd0;
		end else if (go_s1) begin
			out_valid_q <= produce;
			if (hit) begin
				count_q <= count_next;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && produce) begin
			if (hit) begin
				out_q.hit_position <= pos_s1;
				out_q.hit_value    <= rdata;
				out_q.column_end   <= 1'b0;
				out_q.total_count  <= count_next;
			end else begin
				out_q.hit_position <= 16'd0;
				out_q.hit_value    <= 64'd0;
				out_q.column_end   <= 1'b1;
				out_q.total_count  <= count_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
